// File: design/multiply_divide_unit_top_defines.svh
// Assertion macros for the multiply divide unit.
`ifndef MULTIPLY_DIVIDE_UNIT_TOP_DEFINES_SVH
`define MULTIPLY_DIVIDE_UNIT_TOP_DEFINES_SVH
`ifndef SYNTHESIS
`define MDU_ASSERT(label, prop) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error("mdu check");
`define MDU_ASSERT_ALL(label, prop) \
  label: assert property (@(posedge clk) prop) else $error("mdu check");
`else
`define MDU_ASSERT(label, prop)
`define MDU_ASSERT_ALL(label, prop)
`endif
`endif

// File: design/mdu_pkg.sv
// Shared types and constants for the multiply divide unit.
package mdu_pkg;
  localparam int DEFAULT_DATA_WIDTH = 64;

  typedef enum logic [2:0] {
    KIND_MUL    = 3'd0,
    KIND_MULH   = 3'd1,
    KIND_MULHSU = 3'd2,
    KIND_MULHU  = 3'd3,
    KIND_DIV    = 3'd4,
    KIND_DIVU   = 3'd5,
    KIND_REM    = 3'd6,
    KIND_REMU   = 3'd7
  } kind_t;

  typedef struct packed {
    kind_t       kind;
    logic [63:0] first_operand;
    logic [63:0] second_operand;
    logic [4:0]  dest_reg;
    logic [63:0] instr_pc;
    logic [1:0]  slot_tag;
  } in_t;

  typedef struct packed {
    logic [63:0] result_value;
    logic [4:0]  result_dest;
    logic [63:0] result_pc;
    logic [1:0]  result_slot;
  } out_t;

  // Fields that ride along the chain untouched
  typedef struct packed {
    kind_t       kind;
    logic        dz;
    logic [4:0]  dest;
    logic [63:0] pc;
    logic [1:0]  slot;
  } side_t;
endpackage

// File: design/mdu_cell.sv
// One step cell: one shift-add multiply step or one restoring divide step.
module mdu_cell #(
  parameter int DATA_WIDTH = mdu_pkg::DEFAULT_DATA_WIDTH
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  en,
  input  logic                  vld_i,
  input  mdu_pkg::side_t        side_i,
  input  logic [DATA_WIDTH-1:0] x_i,
  input  logic [DATA_WIDTH-1:0] y_i,
  input  logic [DATA_WIDTH-1:0] hi_i,
  input  logic [DATA_WIDTH-1:0] lo_i,
  input  logic [DATA_WIDTH-1:0] a_i,
  input  logic [DATA_WIDTH-1:0] b_i,
  output logic                  vld_o,
  output mdu_pkg::side_t        side_o,
  output logic [DATA_WIDTH-1:0] x_o,
  output logic [DATA_WIDTH-1:0] y_o,
  output logic [DATA_WIDTH-1:0] hi_o,
  output logic [DATA_WIDTH-1:0] lo_o,
  output logic [DATA_WIDTH-1:0] a_o,
  output logic [DATA_WIDTH-1:0] b_o
);
  logic                  vld_r;
  mdu_pkg::side_t        side_r;
  logic [DATA_WIDTH-1:0] x_r, y_r, hi_r, lo_r, a_r, b_r;
  logic [DATA_WIDTH-1:0] x_nxt, hi_nxt, lo_nxt;
  logic [DATA_WIDTH:0]   sum, rem, diff;
  logic                  ge;

  // Compute one step of either operation
  always_comb begin
    sum  = {1'b0, hi_i} + (x_i[0] ? {1'b0, y_i} : {(DATA_WIDTH+1){1'b0}});
    rem  = {hi_i, x_i[DATA_WIDTH-1]};
    diff = rem - {1'b0, y_i};
    ge   = (rem >= {1'b0, y_i});
    if (side_i.kind[2]) begin
      hi_nxt = ge ? diff[DATA_WIDTH-1:0] : rem[DATA_WIDTH-1:0];
      x_nxt  = {x_i[DATA_WIDTH-2:0], ge};
      lo_nxt = lo_i;
    end else begin
      hi_nxt = sum[DATA_WIDTH:1];
      lo_nxt = {sum[0], lo_i[DATA_WIDTH-1:1]};
      x_nxt  = {1'b0, x_i[DATA_WIDTH-1:1]};
    end
  end

  // Advance the stage when the chain moves
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else if (en) begin
      vld_r <= vld_i;
    end
    if (en) begin
      side_r <= side_i;
      x_r    <= x_nxt;
      y_r    <= y_i;
      hi_r   <= hi_nxt;
      lo_r   <= lo_nxt;
      a_r    <= a_i;
      b_r    <= b_i;
    end
  end

  assign vld_o  = vld_r;
  assign side_o = side_r;
  assign x_o    = x_r;
  assign y_o    = y_r;
  assign hi_o   = hi_r;
  assign lo_o   = lo_r;
  assign a_o    = a_r;
  assign b_o    = b_r;
endmodule

// File: design/multiply_divide_unit_top.sv
// Throughput: one request per cycle unless a finished result waits to be taken;
// a chain of DATA_WIDTH step cells, one multiply or divide bit per cell,
// sets the latency.
// The whole chain stalls only while a finished result is not taken.
// Reset: synchronous active-low rst_n clears all stage valid bits.
`include "multiply_divide_unit_top_defines.svh"
module multiply_divide_unit_top #(
  parameter int DATA_WIDTH = mdu_pkg::DEFAULT_DATA_WIDTH
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_valid,
  output logic          in_ready,
  input  mdu_pkg::in_t  in_data,
  output logic          out_valid,
  input  logic          out_ready,
  output mdu_pkg::out_t out_data
);
  localparam int W = DATA_WIDTH;

  logic                 en;
  logic                 vld_w  [W+1];
  mdu_pkg::side_t       side_w [W+1];
  logic [W-1:0]         x_w [W+1], y_w [W+1], hi_w [W+1], lo_w [W+1];
  logic [W-1:0]         a_w [W+1], b_w [W+1];

  logic                 s0_vld_r;
  mdu_pkg::side_t       s0_side_r, s0_side_nxt;
  logic [W-1:0]         s0_x_r, s0_y_r, s0_a_r, s0_b_r, s0_x_nxt, s0_y_nxt;
  logic [W-1:0]         op_a, op_b;
  logic                 sgn_div;

  logic                 out_valid_r;
  mdu_pkg::out_t        out_data_r, out_data_nxt;

  assign en       = !out_valid_r || out_ready;
  assign in_ready = en;

  // Prepare operands: magnitudes for signed divides
  always_comb begin
    op_a    = in_data.first_operand[W-1:0];
    op_b    = in_data.second_operand[W-1:0];
    sgn_div = (in_data.kind == mdu_pkg::KIND_DIV) || (in_data.kind == mdu_pkg::KIND_REM);
    if (in_data.kind[2]) begin
      s0_x_nxt = (sgn_div && op_a[W-1]) ? (~op_a + 1'b1) : op_a;
      s0_y_nxt = (sgn_div && op_b[W-1]) ? (~op_b + 1'b1) : op_b;
    end else begin
      s0_x_nxt = op_a;
      s0_y_nxt = op_b;
    end
    s0_side_nxt.kind = in_data.kind;
    s0_side_nxt.dz   = (op_b == '0);
    s0_side_nxt.dest = in_data.dest_reg;
    s0_side_nxt.pc   = in_data.instr_pc;
    s0_side_nxt.slot = in_data.slot_tag;
  end

  // Hold the entry stage
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s0_vld_r <= 1'b0;
    end else if (en) begin
      s0_vld_r <= in_valid;
    end
    if (en) begin
      s0_side_r <= s0_side_nxt;
      s0_x_r    <= s0_x_nxt;
      s0_y_r    <= s0_y_nxt;
      s0_a_r    <= op_a;
      s0_b_r    <= op_b;
    end
  end

  assign vld_w[0]  = s0_vld_r;
  assign side_w[0] = s0_side_r;
  assign x_w[0]    = s0_x_r;
  assign y_w[0]    = s0_y_r;
  assign hi_w[0]   = '0;
  assign lo_w[0]   = '0;
  assign a_w[0]    = s0_a_r;
  assign b_w[0]    = s0_b_r;

  // Chain of step cells
  for (genvar i = 0; i < W; i++) begin : g_cell
    mdu_cell #(.DATA_WIDTH(W)) u_cell (
      .clk    (clk),
      .rst_n  (rst_n),
      .en     (en),
      .vld_i  (vld_w[i]),
      .side_i (side_w[i]),
      .x_i    (x_w[i]),
      .y_i    (y_w[i]),
      .hi_i   (hi_w[i]),
      .lo_i   (lo_w[i]),
      .a_i    (a_w[i]),
      .b_i    (b_w[i]),
      .vld_o  (vld_w[i+1]),
      .side_o (side_w[i+1]),
      .x_o    (x_w[i+1]),
      .y_o    (y_w[i+1]),
      .hi_o   (hi_w[i+1]),
      .lo_o   (lo_w[i+1]),
      .a_o    (a_w[i+1]),
      .b_o    (b_w[i+1])
    );
  end

  // Fix signs and special cases of the finished request
  logic [W-1:0] fa, fb, prod_hi, quo, rmd, res;
  logic         an, bn;
  always_comb begin
    fa = a_w[W];
    fb = b_w[W];
    an = fa[W-1];
    bn = fb[W-1];
    prod_hi = hi_w[W] - ((an && side_w[W].kind != mdu_pkg::KIND_MULHU) ? fb : '0)
                      - ((bn && side_w[W].kind == mdu_pkg::KIND_MULH) ? fa : '0);
    quo = x_w[W];
    rmd = hi_w[W];
    unique case (side_w[W].kind)
      mdu_pkg::KIND_MUL:    res = lo_w[W];
      mdu_pkg::KIND_MULH,
      mdu_pkg::KIND_MULHSU,
      mdu_pkg::KIND_MULHU:  res = prod_hi;
      mdu_pkg::KIND_DIV:    res = side_w[W].dz ? '1 : ((an ^ bn) ? (~quo + 1'b1) : quo);
      mdu_pkg::KIND_DIVU:   res = side_w[W].dz ? '1 : quo;
      mdu_pkg::KIND_REM:    res = side_w[W].dz ? fa : (an ? (~rmd + 1'b1) : rmd);
      mdu_pkg::KIND_REMU:   res = side_w[W].dz ? fa : rmd;
      default:              res = '0;
    endcase
    out_data_nxt.result_value = 64'(res);
    out_data_nxt.result_dest  = side_w[W].dest;
    out_data_nxt.result_pc    = side_w[W].pc;
    out_data_nxt.result_slot  = side_w[W].slot;
  end

  // Hold the result until taken
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (en) begin
      out_valid_r <= vld_w[W];
    end
    if (en) begin
      out_data_r <= out_data_nxt;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  `MDU_ASSERT(a_accept_enters, (in_valid && in_ready) |=> s0_vld_r)
  `MDU_ASSERT(a_last_to_out, (vld_w[W] && en) |=> out_valid_r)
  `MDU_ASSERT(a_stall_holds, (!en) |=> ($stable(s0_vld_r) && $stable(vld_w[W])))
  `MDU_ASSERT_ALL(a_reset_clears, (!rst_n) |=> (!out_valid_r && !s0_vld_r))
endmodule
